[design/bpeu_pkg.sv]
package bpeu_pkg;

  localparam int Q_W = 32;
  localparam int VERTEX_W = 10;
  localparam int SLOT_W = 16;
  localparam int MODE_W = 2;

  localparam int DEF_MAX_VERTICES = 1024;
  localparam int DEF_FRAC_BITS = 16;
  localparam int DEF_MAX_EDGES = 65536;

  localparam logic [MODE_W-1:0] MODE_LOAD = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
  localparam logic [MODE_W-1:0] MODE_EDGE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SWAP = 2'd3;

  typedef logic signed [Q_W-1:0] q_t;

endpackage

[design/belief_propagation_edge_update_top.sv]
// Two-state message update engine. A request is taken when start is high and
// busy is low. Load, clear-next and swap requests finish in the cycle they are
// taken, so they can follow one another in every cycle. An edge request holds
// busy through the states S_M1 to S_M4, set by the chain of two multiplies,
// the sum and the update multiply of the next product, each registered. The
// result of an edge request is shown for the single cycle in which strobe is
// high, the S_M4 cycle of the update multiply; the receiver cannot stall it,
// so it must take every result at once.
module belief_propagation_edge_update_top #(
  parameter int MAX_VERTICES = bpeu_pkg::DEF_MAX_VERTICES,
  parameter int FRAC_BITS = bpeu_pkg::DEF_FRAC_BITS,
  parameter int MAX_EDGES = bpeu_pkg::DEF_MAX_EDGES
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [bpeu_pkg::MODE_W-1:0]         mode,
  input  logic [bpeu_pkg::VERTEX_W-1:0]       dst_vertex,
  input  logic [bpeu_pkg::VERTEX_W-1:0]       src_vertex,
  input  logic [bpeu_pkg::SLOT_W-1:0]         edge_number,
  input  bpeu_pkg::q_t                        weight_00,
  input  bpeu_pkg::q_t                        weight_01,
  input  bpeu_pkg::q_t                        weight_10,
  input  bpeu_pkg::q_t                        weight_11,
  input  bpeu_pkg::q_t                        value_0,
  input  bpeu_pkg::q_t                        value_1,
  input  logic [bpeu_pkg::SLOT_W-1:0]         offset_value,
  output logic                                strobe,
  output logic [bpeu_pkg::SLOT_W-1:0]         edge_slot,
  output bpeu_pkg::q_t                        belief_0,
  output bpeu_pkg::q_t                        belief_1
);
  import bpeu_pkg::*;

  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int RECIP_SH = 20;
  localparam int RECIP_W = RECIP_SH + 1;
  localparam int RECIP = ((1 << RECIP_SH) + MAX_VERTICES - 1) / MAX_VERTICES;
  localparam int SLOT_LIMIT = (MAX_EDGES - 1 > 65535) ? 65535 : MAX_EDGES - 1;
  localparam int E_W = 2 * Q_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_M1 = 3'd1;
  localparam logic [2:0] S_M2 = 3'd2;
  localparam logic [2:0] S_M3 = 3'd3;
  localparam logic [2:0] S_M4 = 3'd4;

  function automatic logic [AW-1:0] vidx(input logic [VERTEX_W-1:0] v);
    logic [RECIP_W+VERTEX_W-1:0] prod;
    logic [VERTEX_W-1:0] q;
    logic [VERTEX_W-1:0] r;
    prod = (RECIP_W + VERTEX_W)'(v) * (RECIP_W + VERTEX_W)'(RECIP);
    q = VERTEX_W'(prod >> RECIP_SH);
    r = v - VERTEX_W'(q * VERTEX_W'(MAX_VERTICES));
    if (MAX_VERTICES >= (1 << VERTEX_W)) begin
      return AW'(v);
    end
    return AW'(r);
  endfunction

  function automatic q_t sat(input logic signed [E_W-1:0] v);
    if (v > E_W'(64'sh7fffffff)) begin
      return {1'b0, {(Q_W-1){1'b1}}};
    end
    if (v < -E_W'(64'sh80000000)) begin
      return {1'b1, {(Q_W-1){1'b0}}};
    end
    return v[Q_W-1:0];
  endfunction

  function automatic q_t qmul(input q_t a, input q_t b);
    logic signed [E_W-1:0] p;
    p = E_W'(a) * E_W'(b);
    return sat(p >>> FRAC_BITS);
  endfunction

  function automatic q_t qadd(input q_t a, input q_t b);
    logic signed [E_W-1:0] s;
    s = E_W'(a) + E_W'(b);
    return sat(s);
  endfunction

  localparam q_t ONE = q_t'(1) <<< FRAC_BITS;

  logic [2:0] state;
  logic [2:0] state_next;
  logic bank_select;
  logic accept;
  logic [AW-1:0] d_idx;
  logic [AW-1:0] s_idx;
  logic [AW-1:0] dst_reg;
  logic [SLOT_W-1:0] edge_reg;
  q_t w_reg [2][2];
  q_t m1 [2][2];
  q_t m2 [2][2];

  logic [E_W-1:0] pot_mem [MAX_VERTICES];
  logic [SLOT_W-1:0] off_mem [MAX_VERTICES];
  logic [E_W-1:0] bank_a_mem [MAX_VERTICES];
  logic [E_W-1:0] bank_b_mem [MAX_VERTICES];
  logic [E_W-1:0] pot_rd;
  logic [SLOT_W-1:0] off_rd;
  logic [E_W-1:0] bank_a_rd;
  logic [E_W-1:0] bank_b_rd;

  logic [E_W-1:0] cur_rd;
  logic [E_W-1:0] nxt_rd;
  q_t pot_v [2];
  q_t cur_v [2];
  logic [E_W-1:0] upd_data;
  logic load_cur;
  logic clear_nxt;
  logic we_a;
  logic we_b;
  logic [AW-1:0] wa_a;
  logic [AW-1:0] wa_b;
  logic [E_W-1:0] wd_a;
  logic [E_W-1:0] wd_b;
  logic [SLOT_W:0] slot_sum;

  assign busy = (state != S_IDLE);
  assign accept = start && !busy;
  assign d_idx = vidx(dst_vertex);
  assign s_idx = vidx(src_vertex);

  assign cur_rd = bank_select ? bank_b_rd : bank_a_rd;
  assign nxt_rd = bank_select ? bank_a_rd : bank_b_rd;
  assign pot_v[0] = pot_rd[Q_W-1:0];
  assign pot_v[1] = pot_rd[E_W-1:Q_W];
  assign cur_v[0] = cur_rd[Q_W-1:0];
  assign cur_v[1] = cur_rd[E_W-1:Q_W];
  assign upd_data = {qmul(nxt_rd[E_W-1:Q_W], belief_1), qmul(nxt_rd[Q_W-1:0], belief_0)};
  assign slot_sum = (SLOT_W + 1)'(off_rd) + (SLOT_W + 1)'(edge_reg);

  always_comb begin
    load_cur = 1'b0;
    clear_nxt = 1'b0;
    unique case (mode) inside
      MODE_LOAD: load_cur = accept;
      MODE_CLEAR: clear_nxt = accept;
      MODE_EDGE, MODE_SWAP: begin
      end
      default: begin
      end
    endcase
  end

  // product bank write ports: load hits current, clear and edge update hit next
  always_comb begin
    we_a = (load_cur && !bank_select) || (clear_nxt && bank_select) ||
           (state == S_M4 && bank_select);
    we_b = (load_cur && bank_select) || (clear_nxt && !bank_select) ||
           (state == S_M4 && !bank_select);
    wa_a = (state == S_M4) ? dst_reg : d_idx;
    wa_b = wa_a;
    wd_a = (state == S_M4) ? upd_data : {ONE, ONE};
    wd_b = wd_a;
  end

  always_ff @(posedge clk) begin
    if (load_cur) begin
      pot_mem[d_idx] <= {value_1, value_0};
    end
    if (accept) begin
      pot_rd <= pot_mem[d_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (load_cur) begin
      off_mem[d_idx] <= offset_value;
    end
    if (accept) begin
      off_rd <= off_mem[s_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (we_a) begin
      bank_a_mem[wa_a] <= wd_a;
    end
    if (accept) begin
      bank_a_rd <= bank_a_mem[d_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (we_b) begin
      bank_b_mem[wa_b] <= wd_b;
    end
    if (accept) begin
      bank_b_rd <= bank_b_mem[d_idx];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept && mode == MODE_EDGE) state_next = S_M1;
      S_M1: state_next = S_M2;
      S_M2: state_next = S_M3;
      S_M3: state_next = S_M4;
      S_M4: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      bank_select <= 1'b0;
      strobe <= 1'b0;
    end else begin
      state <= state_next;
      strobe <= (state == S_M3);
      if (accept && mode == MODE_SWAP) begin
        bank_select <= !bank_select;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dst_reg <= d_idx;
      edge_reg <= edge_number;
      w_reg[0][0] <= weight_00;
      w_reg[0][1] <= weight_01;
      w_reg[1][0] <= weight_10;
      w_reg[1][1] <= weight_11;
    end
    if (state == S_M1) begin
      for (int i = 0; i < 2; i++) begin
        for (int j = 0; j < 2; j++) begin
          m1[i][j] <= qmul(pot_v[j], w_reg[i][j]);
        end
      end
    end
    if (state == S_M2) begin
      for (int i = 0; i < 2; i++) begin
        for (int j = 0; j < 2; j++) begin
          m2[i][j] <= qmul(m1[i][j], cur_v[j]);
        end
      end
    end
    if (state == S_M3) begin
      belief_0 <= qadd(m2[0][0], m2[0][1]);
      belief_1 <= qadd(m2[1][0], m2[1][1]);
      edge_slot <= (slot_sum > (SLOT_W + 1)'(SLOT_LIMIT)) ? SLOT_W'(SLOT_LIMIT)
                                                          : slot_sum[SLOT_W-1:0];
    end
  end

  a_edge_len: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> ##4 !busy)
    else $error("edge request did not finish in five cycles");

  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> busy && state == S_M4)
    else $error("result strobe outside the update cycle");

  a_edge_takes: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && mode == MODE_EDGE) |=> busy ##3 strobe)
    else $error("edge request gave no result");

  a_bank_swap: assert property (@(posedge clk) disable iff (rst)
    !$stable(bank_select) |-> $past(start && !busy && mode == MODE_SWAP))
    else $error("bank select changed without a swap request");

endmodule
